FILE: rtl/utf8_to_utf16_transcoder_top_macros.svh
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define U8U16_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/u8u16_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEAD = 2'd1,
		ST_TRUNC    = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic {
		REG_BEGIN_CHAR = 1'b0,
		REG_END_CHAR   = 1'b1
	} reg_idx_t;

	// One result item
	typedef struct packed {
		logic [15:0] unit;
		logic        unit_valid;
		logic        run_last;
		status_t     status;
	} res_t;

	// Decoder to result queue: up to two results per byte
	typedef struct packed {
		res_t       r0;
		res_t       r1;
		logic [1:0] cnt;
	} dec_out_t;

	localparam int CFG_BITS = 20;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_BITS = $clog2(RQ_DEPTH);
	localparam int RQ_LVL_BITS = $clog2(RQ_DEPTH + 1);

	localparam logic [20:0] CP_MAX = 21'h10FFFF;
	localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;

endpackage

FILE: rtl/u8u16_decode.sv
// Byte decoder: sequence state, character index and UTF-16 unit forming.
module u8u16_decode #(
	parameter int INDEX_BITS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   string_last,
	input  logic [INDEX_BITS-1:0]  begin_char,
	input  logic [INDEX_BITS-1:0]  end_char,
	output u8u16_pkg::dec_out_t    dec
);

	logic [1:0]            left_q, left_nxt;
	logic [20:0]           acc_q, acc_nxt, acc_sh;
	logic [INDEX_BITS-1:0] idx_q, idx_nxt, idx_inc;
	logic                  halted_q, halted_nxt;

	logic                  done, complete, limited, in_range;
	u8u16_pkg::status_t    st;
	logic [20:0]           cp, v;
	u8u16_pkg::res_t       r0, r1;
	logic [1:0]            cnt;

	assign acc_sh  = {acc_q[14:0], data_byte[5:0]};
	assign idx_inc = idx_q + INDEX_BITS'(1);
	assign limited = (end_char != '1);
	assign in_range = (idx_q >= begin_char) && (!limited || (idx_q < end_char));
	assign v = cp - u8u16_pkg::CP_SUPP_BASE;

	always_comb begin
		left_nxt   = left_q;
		acc_nxt    = acc_q;
		idx_nxt    = idx_q;
		halted_nxt = halted_q;
		done       = 1'b0;
		complete   = 1'b0;
		st         = u8u16_pkg::ST_OK;
		cp         = '0;
		r0         = '0;
		r1         = '0;
		cnt        = 2'd0;

		if (halted_q) begin
			if (string_last) begin
				left_nxt   = '0;
				acc_nxt    = '0;
				idx_nxt    = '0;
				halted_nxt = 1'b0;
			end
		end else begin
			if (left_q == 2'd0) begin
				if (data_byte == 8'h00) begin
					done = 1'b1;
				end else if (!data_byte[7]) begin
					cp = {13'd0, data_byte};
					complete = 1'b1;
				end else if (data_byte[7:5] == 3'b110) begin
					acc_nxt  = {16'd0, data_byte[4:0]};
					left_nxt = 2'd1;
				end else if (data_byte[7:4] == 4'b1110) begin
					acc_nxt  = {17'd0, data_byte[3:0]};
					left_nxt = 2'd2;
				end else if (data_byte[7:3] == 5'b11110) begin
					acc_nxt  = {18'd0, data_byte[2:0]};
					left_nxt = 2'd3;
				end else begin
					done = 1'b1;
					st   = u8u16_pkg::ST_BAD_LEAD;
				end
			end else begin
				acc_nxt  = acc_sh;
				left_nxt = left_q - 2'd1;
				if (left_q == 2'd1) begin
					cp = acc_sh;
					complete = 1'b1;
				end
			end

			// string ends inside a sequence
			if (!done && !complete && string_last) begin
				done = 1'b1;
				st   = u8u16_pkg::ST_TRUNC;
			end

			if (complete) begin
				if (cp > u8u16_pkg::CP_MAX) begin
					done = 1'b1;
					st   = u8u16_pkg::ST_RANGE;
				end else begin
					if (in_range) begin
						if (cp[20:16] == 5'd0) begin
							r0  = '{unit: cp[15:0], unit_valid: 1'b1, run_last: 1'b0,
								status: u8u16_pkg::ST_OK};
							cnt = 2'd1;
						end else begin
							r0  = '{unit: {u8u16_pkg::HI_SURR_TAG, v[19:10]},
								unit_valid: 1'b1, run_last: 1'b0,
								status: u8u16_pkg::ST_OK};
							r1  = '{unit: {u8u16_pkg::LO_SURR_TAG, v[9:0]},
								unit_valid: 1'b1, run_last: 1'b0,
								status: u8u16_pkg::ST_OK};
							cnt = 2'd2;
						end
						if (limited && (idx_inc == end_char))
							done = 1'b1;
					end
					if (idx_q != '1)
						idx_nxt = idx_inc;
					if (string_last)
						done = 1'b1;
				end
			end

			if (done) begin
				if (cnt == 2'd0) begin
					r0  = '0;
					cnt = 2'd1;
				end
				if (cnt == 2'd2) begin
					r1.run_last = 1'b1;
					r1.status   = st;
				end else begin
					r0.run_last = 1'b1;
					r0.status   = st;
				end
				if (string_last) begin
					left_nxt   = '0;
					acc_nxt    = '0;
					idx_nxt    = '0;
					halted_nxt = 1'b0;
				end else begin
					halted_nxt = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			acc_q    <= '0;
			idx_q    <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			left_q   <= left_nxt;
			acc_q    <= acc_nxt;
			idx_q    <= idx_nxt;
			halted_q <= halted_nxt;
		end
	end

	assign dec = '{r0: r0, r1: r1, cnt: cnt};

endmodule

FILE: rtl/u8u16_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
module u8u16_res_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          push_cnt,
	input  u8u16_pkg::res_t                     r0,
	input  u8u16_pkg::res_t                     r1,
	input  logic                                pop,
	output u8u16_pkg::res_t                     head,
	output logic [u8u16_pkg::RQ_LVL_BITS-1:0]   level
);

	u8u16_pkg::res_t                     mem_q [u8u16_pkg::RQ_DEPTH];
	logic [u8u16_pkg::RQ_PTR_BITS-1:0]   wp_q, rp_q, wp_p1;
	logic [u8u16_pkg::RQ_LVL_BITS-1:0]   lvl_q;

	assign wp_p1 = wp_q + u8u16_pkg::RQ_PTR_BITS'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wp_q] <= r0;
		if (push_cnt == 2'd2)
			mem_q[wp_p1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			lvl_q <= '0;
		end else begin
			wp_q  <= wp_q + u8u16_pkg::RQ_PTR_BITS'(push_cnt);
			rp_q  <= rp_q + u8u16_pkg::RQ_PTR_BITS'(pop);
			lvl_q <= lvl_q + u8u16_pkg::RQ_LVL_BITS'(push_cnt)
				- u8u16_pkg::RQ_LVL_BITS'(pop);
		end
	end

	assign head  = mem_q[rp_q];
	assign level = lvl_q;

endmodule

FILE: rtl/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Usage:
//  - s_* stream: one UTF-8 byte per request in s_tdata, s_tlast on the final
//    byte of the string. m_* stream: one UTF-16 unit per request; m_tuser
//    says whether a unit is present and gives the run status on the last one.
//  - cfg_*: begin_char (index 0) and end_char (index 1), written while idle.
//  - A byte accepted at s_* sits in the input register, and is decoded and
//    queued when it leaves that register; its units then reach m_* behind
//    any results still queued, and a queue short of room holds it there.
//  - Throughput: one byte per cycle while the result queue has room. A code
//    point above 0xFFFF yields a surrogate pair, two units from its four
//    bytes, so the output port at one unit a cycle keeps up with the input.
//  - A four-entry result queue sits behind the decoder. A byte leaves the
//    input register only when two queue slots are free, so a stalled receiver
//    backs up into s_tready after the queue and the input register fill.
//  - Reset clears the sequence state, character index, halt flag, queue and
//    input register; begin_char resets to 0 and end_char to all ones (no
//    limit). A run ends on NUL, bad lead, truncation, oversize code point or
//    end_char; later bytes are dropped until the byte marked s_tlast.

`include "utf8_to_utf16_transcoder_top_macros.svh"

module utf8_to_utf16_transcoder_top #(
	parameter int INDEX_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [19:0] cfg_data,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // string_last
	// UTF-16 stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] utf16_unit
	output logic [2:0]  m_tuser,   // [0] unit_valid, [2:1] status
	output logic        m_tlast    // run_last
);

	// Registers hold min(INDEX_BITS, 20) meaningful bits.
	localparam int WIDE = (INDEX_BITS > u8u16_pkg::CFG_BITS) ? INDEX_BITS
		: u8u16_pkg::CFG_BITS;
	localparam logic [WIDE-1:0] END_RST_W = WIDE'(20'hFFFFF);

	logic [WIDE-1:0]       cfg_wide;
	logic [INDEX_BITS-1:0] begin_q, end_q;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  adv;

	u8u16_pkg::dec_out_t   dec;
	u8u16_pkg::res_t       head;
	logic [u8u16_pkg::RQ_LVL_BITS-1:0] level;
	logic [1:0]            push_cnt;
	logic                  pop;

	assign cfg_wide = WIDE'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q <= '0;
			end_q   <= END_RST_W[INDEX_BITS-1:0];
		end else if (cfg_wr_en) begin
			if (cfg_index == u8u16_pkg::REG_BEGIN_CHAR)
				begin_q <= cfg_wide[INDEX_BITS-1:0];
			else
				end_q <= cfg_wide[INDEX_BITS-1:0];
		end
	end

	// Input register; advances when the queue has room for a surrogate pair.
	assign adv = valid_s1
		&& (level <= u8u16_pkg::RQ_LVL_BITS'(u8u16_pkg::RQ_DEPTH - 2));
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	u8u16_decode #(
		.INDEX_BITS (INDEX_BITS)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.data_byte   (byte_s1),
		.string_last (last_s1),
		.begin_char  (begin_q),
		.end_char    (end_q),
		.dec         (dec)
	);

	assign push_cnt = adv ? dec.cnt : 2'd0;
	assign pop      = m_tvalid && m_tready;

	u8u16_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.r0       (dec.r0),
		.r1       (dec.r1),
		.pop      (pop),
		.head     (head),
		.level    (level)
	);

	assign m_tvalid = (level != '0);
	assign m_tdata  = head.unit;
	assign m_tuser  = {head.status, head.unit_valid};
	assign m_tlast  = head.run_last;

	// A result without a unit only ever closes a run, and carries a zero unit.
	`U8U16_ASSERT_NOW(a_empty_is_last, m_tvalid && !m_tuser[0], m_tlast, "empty result not last")
	`U8U16_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata == 16'd0, "empty result has data")
	// Error status appears only on the closing result of a run.
	`U8U16_ASSERT_NOW(a_status_last, m_tvalid && (m_tuser[2:1] != u8u16_pkg::ST_OK), m_tlast, "status not on last")
	// Nothing queued and nothing decoded: output stays idle next cycle.
	`U8U16_ASSERT_NXT(a_idle_out, (level == '0) && !adv, !m_tvalid, "result from nowhere")

endmodule

FILE: verif/utf8_to_utf16_transcoder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 to UTF-16 transcoder top level.
module utf8_to_utf16_transcoder_top_tb;

	localparam int CLK_HALF = 2;               // 4 ns clock
	localparam int RESET_CYCLES = 9;
	localparam logic [19:0] INDEX_ALL = 20'hFFFFF;  // end_char value meaning "no limit"
	localparam int SETTLE_CYCLES = 6;          // spare wait after the last expected request
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 80;       // long receiver stall for back-pressure
	localparam int RUN_LIMIT_NS = 1_000_000;   // far above a slow clean run
	localparam int PHASE_BYTES = 150;          // minimum bytes per random configuration phase
	localparam int MAX_PRINTED = 100;

	// One expected output request
	typedef struct packed {
		logic [15:0]          unit;
		logic                 unit_valid;
		logic                 run_last;
		u8u16_pkg::status_t   status;
	} utf16_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [0:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] data_byte
	logic        s_tlast;    // string_last
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [15:0] utf16_unit
	logic [2:0]  m_tuser;    // [0] unit_valid, [2:1] status
	logic        m_tlast;    // run_last

	// Transcoder model state: string decode state plus the emission window
	logic [1:0]  pend_cont;     // continuation bytes still owed
	logic [20:0] cp_acc;        // code point being built
	logic [19:0] char_cnt;      // completed characters in this string (saturates)
	logic        run_over;      // run ended, dropping bytes until string end
	logic [19:0] win_begin;     // begin_char copy
	logic [19:0] stop_char;     // end_char copy

	utf16_res_t units_due[$];   // expected output requests, oldest first
	int         err_count;

	// Sender pacing
	bit         tx_gaps_on;
	bit         tx_held;        // s_tvalid left high after the last accepted request
	int         burst_left;

	// Receiver long hold-off, picked up by the receiver process
	int         rx_hold_req;

	utf8_to_utf16_transcoder_top #(
		.INDEX_BITS(20)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#RUN_LIMIT_NS;
		$display("[utf8_to_utf16_transcoder_top] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= MAX_PRINTED) begin
			$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		end
	endtask

	function automatic void clear_string_model();
		pend_cont = '0;
		cp_acc = '0;
		char_cnt = '0;
		run_over = 1'b0;
	endfunction

	// Decode one byte and queue the UTF-16 requests it causes.
	function automatic void predict_units(input logic [7:0] b, input logic last);
		utf16_res_t res[2];
		int n;
		logic done;
		logic whole;
		logic limited;
		u8u16_pkg::status_t st;
		logic [20:0] cp;
		logic [20:0] off;
		n = 0;
		done = 1'b0;
		whole = 1'b0;
		st = u8u16_pkg::ST_OK;
		cp = '0;
		off = '0;

		// after a run ends, only the string end matters
		if (run_over) begin
			if (last) clear_string_model();
			return;
		end

		if (pend_cont == 2'd0) begin
			if (b == 8'h00) begin
				done = 1'b1;                    // NUL lead ends the run cleanly
			end else if (b[7] == 1'b0) begin
				cp = {13'd0, b};
				whole = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				cp_acc = {16'd0, b[4:0]};
				pend_cont = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				cp_acc = {17'd0, b[3:0]};
				pend_cont = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				cp_acc = {18'd0, b[2:0]};
				pend_cont = 2'd3;
			end else begin
				done = 1'b1;                    // stray continuation or 0xF8..0xFF
				st = u8u16_pkg::ST_BAD_LEAD;
			end
		end else begin
			// continuation: top two bits are not checked, NUL here is plain data
			cp_acc = {cp_acc[14:0], b[5:0]};
			pend_cont = pend_cont - 2'd1;
			if (pend_cont == 2'd0) begin
				cp = cp_acc;
				whole = 1'b1;
			end
		end

		if (!done && !whole && last) begin
			done = 1'b1;
			st = u8u16_pkg::ST_TRUNC;
		end

		if (whole) begin
			if (cp > u8u16_pkg::CP_MAX) begin
				done = 1'b1;
				st = u8u16_pkg::ST_RANGE;
			end else begin
				limited = (stop_char != INDEX_ALL);
				if (char_cnt >= win_begin && (!limited || char_cnt < stop_char)) begin
					if (cp[20:16] == 5'd0) begin
						res[n] = '{unit: cp[15:0], unit_valid: 1'b1, run_last: 1'b0,
							status: u8u16_pkg::ST_OK};
						n++;
					end else begin
						off = cp - u8u16_pkg::CP_SUPP_BASE;
						res[n] = '{unit: 16'hD800 + off[19:10], unit_valid: 1'b1,
							run_last: 1'b0, status: u8u16_pkg::ST_OK};
						n++;
						res[n] = '{unit: 16'hDC00 + off[9:0], unit_valid: 1'b1,
							run_last: 1'b0, status: u8u16_pkg::ST_OK};
						n++;
					end
					// last character inside the window closes the run
					if (limited && ({1'b0, char_cnt} + 21'd1) == {1'b0, stop_char}) begin
						done = 1'b1;
					end
				end
				if (char_cnt != INDEX_ALL) char_cnt = char_cnt + 20'd1;
				if (last) done = 1'b1;
			end
		end

		if (done) begin
			// run end with nothing to carry: a bare status request
			if (n == 0) begin
				res[0] = '{unit: 16'h0000, unit_valid: 1'b0, run_last: 1'b0,
					status: u8u16_pkg::ST_OK};
				n = 1;
			end
			res[n - 1].run_last = 1'b1;
			res[n - 1].status = st;
			if (last) clear_string_model();
			else run_over = 1'b1;
		end

		for (int i = 0; i < n; i++) units_due.push_back(res[i]);
	endfunction

	// Offer one byte, wait for the request to be taken, then maybe open a gap.
	// Called at a clock step; returns at a step with s_tvalid possibly still high.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_units(b, last);
		tx_held = 1'b1;
		if (tx_gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				tx_held = 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_run(input logic [7:0] bytes_in[$]);
		for (int i = 0; i < bytes_in.size(); i++) begin
			send_byte(bytes_in[i], i == bytes_in.size() - 1);
		end
	endtask

	// Drop s_tvalid in the same step as the last acceptance, if still up.
	task automatic idle_stream();
		if (tx_held) begin
			s_tvalid <= 1'b0;
			tx_held = 1'b0;
		end
	endtask

	// Quiet the input, let every expected request drain, then a few spare cycles
	// so a byte that makes no output has left the pipeline too.
	task automatic wait_idle();
		idle_stream();
		while (units_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers in back-to-back cycles with the block idle.
	task automatic set_window(input logic [19:0] b, input logic [19:0] e);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= u8u16_pkg::REG_BEGIN_CHAR;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= u8u16_pkg::REG_END_CHAR;
		cfg_data <= e;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_begin = b;
		stop_char = e;
	endtask

	// Continuation byte; now and then the unchecked top bits are scrambled.
	function automatic logic [7:0] cont_byte(input logic [5:0] v);
		logic [1:0] tag;
		tag = ($urandom_range(0, 15) == 0) ? 2'($urandom) : 2'b10;
		return {tag, v};
	endfunction

	// Append one randomly chosen character, 1 to 4 bytes. Overlongs,
	// surrogates and out-of-range values show up on purpose.
	function automatic void append_char(ref logic [7:0] q[$]);
		int pick;
		logic [20:0] cp;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			q.push_back(8'($urandom_range(1, 'h7F)));
		end else if (pick < 55) begin
			cp = 21'($urandom_range(0, 'h7FF));
			q.push_back({3'b110, cp[10:6]});
			q.push_back(cont_byte(cp[5:0]));
		end else if (pick < 75) begin
			cp = 21'($urandom_range(0, 'hFFFF));
			q.push_back({4'b1110, cp[15:12]});
			q.push_back(cont_byte(cp[11:6]));
			q.push_back(cont_byte(cp[5:0]));
		end else begin
			cp = (pick < 93) ? 21'($urandom_range(0, 'h10FFFF))
				: 21'($urandom_range(0, 'h1FFFFF));
			q.push_back({5'b11110, cp[20:18]});
			q.push_back(cont_byte(cp[17:12]));
			q.push_back(cont_byte(cp[11:6]));
			q.push_back(cont_byte(cp[5:0]));
		end
	endfunction

	// One random string; most are clean, the rest carry a NUL, a bad lead,
	// or end in the middle of a sequence.
	task automatic send_string(input int n_chars, output int n_bytes);
		logic [7:0] q[$];
		int flaw;
		int at;
		int owed;
		flaw = $urandom_range(0, 9);    // 0..6 clean, 7 NUL, 8 bad lead, 9 cut off
		at = $urandom_range(0, n_chars - 1);
		for (int k = 0; k < n_chars; k++) begin
			if (k == at && flaw == 7) q.push_back(8'h00);
			if (k == at && flaw == 8) begin
				q.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
					: 8'($urandom_range('hF8, 'hFF)));
			end
			append_char(q);
		end
		if (flaw == 9) begin
			owed = $urandom_range(1, 3);
			case (owed)
				1: q.push_back({3'b110, 5'($urandom)});
				2: q.push_back({4'b1110, 4'($urandom)});
				default: q.push_back({5'b11110, 3'($urandom)});
			endcase
			repeat ($urandom_range(0, owed - 1)) q.push_back(cont_byte(6'($urandom)));
		end
		send_run(q);
		n_bytes = q.size();
	endtask

	// An ASCII letter and the largest value of each encoding length, surrogate pair at 0x10FFFF.
	task automatic test_char_forms();
		send_run('{8'h41, 8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
			8'hF4, 8'h8F, 8'hBF, 8'hBF});
	endtask

	// Run ends on bad lead, truncation, NUL and range, and bytes dropped after the end.
	task automatic test_run_ends();
		send_run('{8'h80, 8'h41, 8'h42});          // stray continuation, rest ignored
		send_run('{8'hE2, 8'h82});                 // string ends mid-sequence
		send_run('{8'hC2, 8'h00, 8'h00});          // NUL as data, then NUL lead
		send_run('{8'hF4, 8'h90, 8'h80, 8'h80});   // just above 0x10FFFF
		send_run('{8'hFF});                        // invalid lead on the last byte
	endtask

	// Receiver holds off while the sender keeps offering: the result queue and
	// input register fill and s_tready must drop, then everything drains.
	task automatic test_back_pressure();
		logic [7:0] q[$];
		wait_idle();
		tx_gaps_on = 1'b0;
		rx_hold_req = HOLD_OFF_CYCLES;
		for (int i = 0; i < 12; i++) begin
			q.push_back(8'h30 + 8'(i));
			q.push_back(8'hF0);
			q.push_back(8'h9F);
			q.push_back(8'h98);
			q.push_back(8'h80 + 8'(i));
		end
		q.push_back(8'h5A);
		send_run(q);
		tx_gaps_on = 1'b1;
	endtask

	// Random strings under a sweep of emission windows, extremes included.
	task automatic test_random_strings();
		int sent;
		int nb;
		logic [19:0] b;
		logic [19:0] e;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					b = '0;
					e = INDEX_ALL;
				end
				1: begin
					b = '0;
					e = 20'($urandom_range(1, 6));
				end
				2: begin
					b = 20'($urandom_range(0, 5));
					e = b + 20'($urandom_range(1, 6));
				end
				3: begin
					b = 20'($urandom_range(1, 8));   // empty window
					e = b;
				end
				4: begin
					b = 20'($urandom_range(2, 9));   // begin past end
					e = 20'($urandom_range(0, b - 1));
				end
				5: begin
					b = INDEX_ALL;
					e = '0;
				end
				6: begin
					b = 20'($urandom);
					e = 20'($urandom);
				end
				default: begin
					b = '0;
					e = INDEX_ALL - 20'd1;           // largest real limit
				end
			endcase
			set_window(b, e);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				send_string($urandom_range(1, 10), nb);
				sent += nb;
			end
		end
	endtask

	// Receiver: switches between stall patterns on its own schedule and
	// serves a long hold-off when one is requested.
	initial begin : rx_side
		int mode;
		int left;
		int cyc;
		int hold;
		mode = 0;
		left = 0;
		cyc = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (rx_hold_req > 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(64, 256);
			end
			left--;
			case (mode)
				0: m_tready <= 1'b1;                              // no stalls
				1: m_tready <= ($urandom_range(0, 9) >= 3);       // light random
				2: m_tready <= ($urandom_range(0, 3) == 0);       // heavy random
				default: m_tready <= ((cyc % 5) < 2);             // periodic
			endcase
		end
	end

	// Compare every accepted output request with the oldest expectation.
	always @(posedge clk) begin : unit_check
		utf16_res_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (units_due.size() == 0) begin
				report_mismatch("unexpected request, utf16_unit", m_tdata, 0);
			end else begin
				want = units_due.pop_front();
				if (m_tdata !== want.unit) report_mismatch("utf16_unit", m_tdata, want.unit);
				if (m_tuser[0] !== want.unit_valid) begin
					report_mismatch("unit_valid", m_tuser[0], want.unit_valid);
				end
				if (m_tlast !== want.run_last) report_mismatch("run_last", m_tlast, want.run_last);
				if (m_tuser[2:1] !== want.status) begin
					report_mismatch("status", m_tuser[2:1], want.status);
				end
			end
		end
	end

	initial begin : main_seq
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = u8u16_pkg::REG_BEGIN_CHAR;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		err_count = 0;
		tx_gaps_on = 1'b1;
		tx_held = 1'b0;
		burst_left = 0;
		rx_hold_req = 0;
		win_begin = '0;
		stop_char = INDEX_ALL;
		clear_string_model();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_char_forms();
		test_run_ends();
		test_back_pressure();
		test_random_strings();

		// drain; a missing request ends in the run limit above
		idle_stream();
		while (units_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (units_due.size() != 0) begin
			report_mismatch("requests still due", units_due.size(), 0);
		end

		if (err_count == 0) begin
			$display("[utf8_to_utf16_transcoder_top] OK");
		end else begin
			$display("[utf8_to_utf16_transcoder_top] ERROR");
		end
		$finish;
	end

endmodule

FILE: utf8_to_utf16_transcoder_top.f
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_res_fifo.sv
rtl/utf8_to_utf16_transcoder_top.sv
verif/utf8_to_utf16_transcoder_top_tb.sv
